/* src/fla_pkg.sv */
// Shared types and constants of the free-list block allocator.
package fla_pkg;

  // Fixed widths of the request and result fields.
  localparam int IDX_OUT_W = 4;
  localparam int CNT_OUT_W = 5;

  // Request operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NONE_USED = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_READ
  } state_t;

endpackage

/* src/fla_if.sv */
// Request and result channel interfaces of the free-list block allocator.
interface fla_req_if;
  import fla_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [IDX_OUT_W-1:0] block_index;

  modport source (output valid, output op, output block_index, input ready);
  modport sink (input valid, input op, input block_index, output ready);
endinterface

interface fla_rsp_if;
  import fla_pkg::*;
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [IDX_OUT_W-1:0] granted_index;
  logic [CNT_OUT_W-1:0] free_count;
  logic [CNT_OUT_W-1:0] used_count;

  modport source (output valid, output status, output granted_index, output free_count,
                  output used_count, input ready);
  modport sink (input valid, input status, input granted_index, input free_count,
                input used_count, output ready);
endinterface

/* src/fla_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module fla_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/free_list_block_allocator_unit.sv */
// Free-list allocator over NUM_BLOCKS fixed-size blocks, links held in a RAM.
// A free or a rejected request shows its result in the cycle after its beat is accepted;
// a granted allocation first waits in the READ state for the link RAM's registered read.
// Throughput: one free or rejected request per cycle unless out_if stalls; none in READ.
// Reset: rst_n is synchronous; after release a pass writes the initial link chain,
// one entry a cycle over all NUM_BLOCKS entries, while in_if.ready stays low.
module free_list_block_allocator_unit #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  fla_req_if.sink     in_if,
  fla_rsp_if.source   out_if
);
  import fla_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BLOCKS);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [IDX_OUT_W-1:0] granted_r, granted_nxt;
  logic [CNT_OUT_W-1:0] free_out_r, free_out_nxt;
  logic [CNT_OUT_W-1:0] used_out_r, used_out_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     link_rdata;

  logic                 in_accept;
  logic                 out_take;
  logic [31:0]          idx_wide;
  logic [31:0]          head_wide;
  logic [31:0]          free_wide;
  logic [31:0]          used_wide;
  logic                 idx_in_range;
  logic [IDX_W-1:0]     free_idx;

  fla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  assign out_take     = out_valid_r && out_if.ready;
  assign in_if.ready  = (state_r == FSM_IDLE) && (!out_valid_r || out_if.ready);
  assign in_accept    = in_if.valid && in_if.ready;
  assign idx_wide     = 32'(in_if.block_index);
  assign idx_in_range = idx_wide < NUM_BLOCKS;
  assign free_idx     = idx_wide[IDX_W-1:0];
  assign head_wide    = 32'(head_r);
  assign free_wide    = 32'(free_nxt);
  assign used_wide    = 32'(used_nxt);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    used_nxt      = used_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_take;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    free_out_nxt  = free_out_r;
    used_out_nxt  = used_out_r;
    ram_we        = 1'b0;
    ram_waddr     = free_idx;
    ram_wdata     = head_r;

    unique case (state_r)
      FSM_INIT: begin
        // Entry i links to i - 1; entry 0 closes the chain at the top block.
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = (clr_r == '0) ? LAST_IDX : clr_r - 1'b1;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (in_accept) begin
          granted_nxt = '0;
          if (in_if.op == OP_ALLOC) begin
            if (free_r == '0) begin
              status_nxt    = STAT_EMPTY;
              out_valid_nxt = 1'b1;
            end else begin
              // The link RAM is read at the head this cycle.
              state_nxt = FSM_READ;
            end
          end else begin
            priority if (used_r == '0) begin
              status_nxt = STAT_NONE_USED;
            end else if (!idx_in_range) begin
              status_nxt = STAT_RANGE;
            end else begin
              status_nxt = STAT_DONE;
              ram_we     = 1'b1;
              head_nxt   = free_idx;
              free_nxt   = free_r + 1'b1;
              used_nxt   = used_r - 1'b1;
            end
            out_valid_nxt = 1'b1;
          end
          free_out_nxt = free_wide[CNT_OUT_W-1:0];
          used_out_nxt = used_wide[CNT_OUT_W-1:0];
        end
      end
      FSM_READ: begin
        head_nxt      = link_rdata;
        free_nxt      = free_r - 1'b1;
        used_nxt      = used_r + 1'b1;
        status_nxt    = STAT_DONE;
        granted_nxt   = head_wide[IDX_OUT_W-1:0];
        free_out_nxt  = free_wide[CNT_OUT_W-1:0];
        used_out_nxt  = used_wide[CNT_OUT_W-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_INIT;
      head_r      <= LAST_IDX;
      free_r      <= FULL_CNT;
      used_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    free_out_r <= free_out_nxt;
    used_out_r <= used_out_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = status_r;
  assign out_if.granted_index = granted_r;
  assign out_if.free_count    = free_out_r;
  assign out_if.used_count    = used_out_r;

  // The two counts always account for every block.
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(free_r) + 32'(used_r)) == NUM_BLOCKS)
    else $error("free and used counts do not add up to the pool size");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < NUM_BLOCKS)
    else $error("head index out of range");

  a_alloc_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_if.op == OP_ALLOC) && (free_r != '0) |=> state_r == FSM_READ)
    else $error("granted allocation did not wait for the link read");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_READ |=> out_valid_r && (status_r == STAT_DONE))
    else $error("link read did not produce a result beat");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != FSM_IDLE |-> !in_if.ready)
    else $error("request taken while the link RAM is busy");

endmodule
